[src/dd_odo_pkg.sv]
// dd_odo_pkg: types, constants and helper functions for the differential drive odometry block
// used by dd_odo_arith and diff_drive_odometry_top; no dependencies
package dd_odo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int SH30      = 30 - FRAC_BITS;

    localparam logic signed [63:0] PI30      = 64'sd3373259426;
    localparam logic signed [63:0] TWO_PI30  = 64'sd6746518852;
    localparam logic signed [63:0] HALF_PI30 = 64'sd1686629713;
    localparam logic signed [63:0] QTR_PI30  = 64'sd843314856;
    localparam logic signed [63:0] ONE30     = 64'sd1 <<< 30;

    localparam logic [30:0] RADIUS_RST = 31'd1 << FRAC_BITS;

    typedef enum logic [1:0] {
        FN_DRIVE = 2'd0,
        FN_RATE  = 2'd1,
        FN_LOAD  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_RADIUS = 3'd0,
        CFG_SEP    = 3'd1,
        CFG_SX     = 3'd2,
        CFG_SY     = 3'd3,
        CFG_SHEAD  = 3'd4,
        CFG_SLEFT  = 3'd5,
        CFG_SRIGHT = 3'd6,
        CFG_NONE   = 3'd7
    } t_cfg_idx;

    typedef enum logic {
        AOP_MUL = 1'b0,
        AOP_DIV = 1'b1
    } t_aop;

    typedef struct packed {
        logic start;
        t_aop op;
    } t_arith_req;

    // which angle the wrap unit works on, and so where its result goes
    typedef enum logic [2:0] {
        WC_W    = 3'd0,
        WC_HEAD = 3'd1,
        WC_HNEW = 3'd2,
        WC_LNEW = 3'd3,
        WC_RNEW = 3'd4,
        WC_LDH  = 3'd5,
        WC_LDL  = 3'd6,
        WC_LDR  = 3'd7
    } t_wctx;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_W_MUL,
        ST_W_DIV,
        ST_V_MUL,
        ST_WRAP,
        ST_SC_INIT,
        ST_SC_SQ,
        ST_SC_TM,
        ST_SC_TD,
        ST_SC_FIN,
        ST_DX_MUL,
        ST_DX_DIV,
        ST_DY_MUL,
        ST_DY_DIV,
        ST_EX_MUL1,
        ST_EX_MUL2,
        ST_EY_MUL1,
        ST_EY_MUL2,
        ST_R_MUL,
        ST_RL_DIV,
        ST_RR_DIV,
        ST_OUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // saturated result of a division by zero
    function automatic logic signed [31:0] sat_sign(input logic signed [63:0] v);
        if (v > 64'sd0) begin
            return 32'sh7fffffff;
        end else if (v < 64'sd0) begin
            return 32'sh80000000;
        end
        return 32'sd0;
    endfunction

    // divide by 2^k, truncating toward zero
    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                     input int unsigned k);
        logic signed [63:0] bias;
        bias = v[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (v + bias) >>> k;
    endfunction

    // q.30 angle back to the fixed-point format, round half up
    function automatic logic signed [31:0] to_qf(input logic signed [32:0] a);
        logic signed [33:0] t;
        logic signed [33:0] s;
        t = {a[32], a} + (34'sd1 <<< (SH30 - 1));
        s = t >>> SH30;
        return s[31:0];
    endfunction

    // taylor series divisors for sine (2n)(2n+1) and cosine (2n-1)(2n)
    function automatic logic [7:0] term_div(input logic is_cos, input logic [3:0] n);
        logic [7:0] k;
        k = 8'd1;
        if (!is_cos) begin
            case (n)
                4'd1:    k = 8'd6;
                4'd2:    k = 8'd20;
                4'd3:    k = 8'd42;
                4'd4:    k = 8'd72;
                4'd5:    k = 8'd110;
                4'd6:    k = 8'd156;
                4'd7:    k = 8'd210;
                default: k = 8'd1;
            endcase
        end else begin
            case (n)
                4'd1:    k = 8'd2;
                4'd2:    k = 8'd12;
                4'd3:    k = 8'd30;
                4'd4:    k = 8'd56;
                4'd5:    k = 8'd90;
                4'd6:    k = 8'd132;
                4'd7:    k = 8'd182;
                4'd8:    k = 8'd240;
                default: k = 8'd1;
            endcase
        end
        return k;
    endfunction

endpackage

[src/dd_odo_arith.sv]
// dd_odo_arith: shared bit-serial signed multiplier and restoring divider, one bit per cycle
// depends on dd_odo_pkg
module dd_odo_arith (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dd_odo_pkg::t_arith_req i_req,
    input  logic signed [63:0]     i_a,
    input  logic signed [63:0]     i_b,
    output logic                   o_done,
    output logic signed [63:0]     o_res,
    output logic signed [63:0]     o_rem
);
    import dd_odo_pkg::*;

    logic              r_busy;
    logic              r_fin;
    logic              r_done;
    t_aop              r_op;
    logic [5:0]        r_cnt;
    logic [63:0]       r_x;
    logic [63:0]       r_y;
    logic [63:0]       r_acc;
    logic              r_neg_q;
    logic              r_neg_r;
    logic signed [63:0] r_res;
    logic signed [63:0] r_rem;

    logic [63:0] w_trial;
    logic [63:0] w_sum;

    assign w_trial = {r_acc[62:0], r_x[63]};
    assign w_sum   = r_acc + r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_op    <= i_req.op;
                r_cnt   <= '0;
                r_x     <= i_a[63] ? 64'(-i_a) : 64'(i_a);
                r_y     <= i_b[63] ? 64'(-i_b) : 64'(i_b);
                r_acc   <= '0;
                r_neg_q <= i_a[63] ^ i_b[63];
                r_neg_r <= i_a[63];
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
                unique case (r_op)
                    AOP_MUL: begin
                        if (r_y[0]) begin
                            r_acc <= w_sum;
                        end
                        r_x <= {r_x[62:0], 1'b0};
                        r_y <= {1'b0, r_y[63:1]};
                    end
                    AOP_DIV: begin
                        if (w_trial >= r_y) begin
                            r_acc <= w_trial - r_y;
                            r_x   <= {r_x[62:0], 1'b1};
                        end else begin
                            r_acc <= w_trial;
                            r_x   <= {r_x[62:0], 1'b0};
                        end
                    end
                endcase
            end
            if (r_fin) begin
                if (r_op == AOP_MUL) begin
                    r_res <= r_neg_q ? -$signed(r_acc) : $signed(r_acc);
                end else begin
                    r_res <= r_neg_q ? -$signed(r_x) : $signed(r_x);
                end
                r_rem <= r_neg_r ? -$signed(r_acc) : $signed(r_acc);
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy && !r_fin)
        else $error("arith start while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("arith done longer than one cycle");
    a_start_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> r_busy && !r_done)
        else $error("arith did not start");
`endif
endmodule

[src/diff_drive_odometry_top.sv]
// diff_drive_odometry_top: differential drive odometry, pose and wheel rate sequencer
// depends on dd_odo_pkg and dd_odo_arith
//
// usage
// - s_axis carries one request: tuser is the function code (0 drive, 1 twist to wheel
//   rates, 2 load start pose, 3 report only), tdata the wheel increments and twist
// - m_axis returns exactly one result per request: twist, wheel rates, the invalid flag
//   in tuser and the pose after the request
// - configuration is a plain write port (enable, index, data) used while idle
// - all arithmetic goes through one bit-serial multiply/divide unit; the sine/cosine
//   series sets most of the time that a drive request takes
// - one request is worked on at a time; s_axis_tready is high only while idle
// - the result stays on m_axis until taken; a stalled receiver holds the block
// - synchronous reset clears the pose, the wheel angles and the registers to their
//   defaults (radius and separation 1.0)
module diff_drive_odometry_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // wheel_delta_left, wheel_delta_right, twist_omega, twist_x, twist_y
    input  logic [159:0] s_axis_tdata,
    // func
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // body_omega, body_x, wheel_rate_left, wheel_rate_right, pose_heading, pose_x,
    // pose_y, wheel_angle_left, wheel_angle_right, zero fill
    output logic [255:0] m_axis_tdata,
    // twist_invalid
    output logic [0:0]   m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import dd_odo_pkg::*;

    localparam logic signed [63:0] HEAD_MAX =
        (PI30 + (64'sd1 <<< (SH30 - 1))) >>> SH30;

    // configuration
    logic [30:0]        r_radius;
    logic [30:0]        r_sep;
    logic signed [31:0] r_sx;
    logic signed [31:0] r_sy;
    logic signed [31:0] r_shead;
    logic signed [31:0] r_sleft;
    logic signed [31:0] r_sright;

    // state
    logic signed [31:0] r_head;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_la;
    logic signed [31:0] r_ra;

    // request and result
    logic signed [31:0] r_dl;
    logic signed [31:0] r_dr;
    logic signed [31:0] r_tw;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_w;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_rl;
    logic signed [31:0] r_rr;
    logic               r_inv;

    // working registers
    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    logic signed [31:0] r_sw;
    logic signed [31:0] r_cw;
    logic signed [31:0] r_sh;
    logic signed [31:0] r_ch;
    logic signed [63:0] r_p;
    t_wctx              r_ctx;
    logic signed [32:0] r_ang;
    logic [1:0]         r_quad;
    logic               r_bneg;
    logic [29:0]        r_m;
    logic [30:0]        r_b2;
    logic [30:0]        r_t;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_sb;
    logic               r_cos;
    logic [3:0]         r_n;
    logic               r_issued;

    t_state             r_state;
    t_state             n_state;

    t_arith_req         w_req;
    logic signed [63:0] w_a;
    logic signed [63:0] w_b;
    logic               w_done;
    logic signed [63:0] w_res;
    logic signed [63:0] w_rem;
    logic               w_op_state;
    logic               w_bypass;
    logic               w_adv;
    logic               w_in_acc;
    t_func              w_func;

    logic signed [32:0] w_wsrc;
    logic signed [63:0] w_adj;
    logic signed [32:0] w_ang;
    logic signed [63:0] w_den;
    logic signed [63:0] w_base;
    logic signed [63:0] w_vx_full;
    logic signed [31:0] w_vx_new;

    // sincos range reduction
    logic [32:0]        w_amag;
    logic [33:0]        w_asum;
    logic [1:0]         w_qa;
    logic signed [34:0] w_bred;
    logic [29:0]        w_m;
    logic [1:0]         w_quad;

    // series step
    logic [30:0]        w_tnew;
    logic signed [31:0] w_accnew;

    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    assign w_func   = t_func'(s_axis_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RST;
            r_sep    <= RADIUS_RST;
            r_sx     <= '0;
            r_sy     <= '0;
            r_shead  <= '0;
            r_sleft  <= '0;
            r_sright <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RADIUS: r_radius <= i_cfg_data[30:0];
                CFG_SEP:    r_sep    <= i_cfg_data[30:0];
                CFG_SX:     r_sx     <= i_cfg_data;
                CFG_SY:     r_sy     <= i_cfg_data;
                CFG_SHEAD:  r_shead  <= i_cfg_data;
                CFG_SLEFT:  r_sleft  <= i_cfg_data;
                CFG_SRIGHT: r_sright <= i_cfg_data;
                CFG_NONE:   ;
            endcase
        end
    end

    // angle fed to the wrap unit
    always_comb begin
        unique case (r_ctx)
            WC_W:    w_wsrc = 33'(r_w);
            WC_HEAD: w_wsrc = 33'(r_head);
            WC_HNEW: w_wsrc = 33'(r_head) + 33'(r_w);
            WC_LNEW: w_wsrc = 33'(r_la) + 33'(r_dl);
            WC_RNEW: w_wsrc = 33'(r_ra) + 33'(r_dr);
            WC_LDH:  w_wsrc = 33'(r_shead);
            WC_LDL:  w_wsrc = 33'(r_sleft);
            WC_LDR:  w_wsrc = 33'(r_sright);
        endcase
    end

    // remainder into (-pi, pi]
    always_comb begin
        if (w_rem > PI30) begin
            w_adj = w_rem - TWO_PI30;
        end else if (w_rem <= -PI30) begin
            w_adj = w_rem + TWO_PI30;
        end else begin
            w_adj = w_rem;
        end
        w_ang = w_adj[32:0];
    end

    assign w_den     = 64'(r_w) <<< SH30;
    assign w_base    = 64'(r_tx) <<< (FRAC_BITS + 1);
    assign w_vx_full = shr_trunc(w_res, FRAC_BITS + 1);
    assign w_vx_new  = sat32(w_vx_full);

    // nearest multiple of pi/2
    always_comb begin
        logic [33:0] qah;
        w_amag = r_ang[32] ? 33'(-r_ang) : 33'(r_ang);
        w_asum = 34'(w_amag) + 34'(QTR_PI30);
        if (w_asum >= 34'(PI30)) begin
            w_qa = 2'd2;
            qah  = 34'(PI30);
        end else if (w_asum >= 34'(HALF_PI30)) begin
            w_qa = 2'd1;
            qah  = 34'(HALF_PI30);
        end else begin
            w_qa = 2'd0;
            qah  = 34'd0;
        end
        w_bred = $signed({2'b00, w_amag}) - $signed({1'b0, qah});
        w_m    = w_bred[34] ? 30'(-w_bred) : w_bred[29:0];
        w_quad = r_ang[32] ? 2'(-w_qa) : w_qa;
    end

    assign w_tnew   = w_res[30:0];
    assign w_accnew = r_n[0] ? (r_acc - $signed({1'b0, w_tnew}))
                             : (r_acc + $signed({1'b0, w_tnew}));

    // next state and arithmetic requests
    always_comb begin
        n_state    = r_state;
        w_op_state = 1'b0;
        w_bypass   = 1'b0;
        w_a        = '0;
        w_b        = '0;
        w_req.op   = AOP_MUL;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (w_func)
                        FN_DRIVE: n_state = ST_W_MUL;
                        FN_RATE:  n_state = (s_axis_tdata[159:128] != '0) ? ST_OUT : ST_R_MUL;
                        FN_LOAD:  n_state = ST_WRAP;
                        FN_NONE:  n_state = ST_OUT;
                    endcase
                end
            end
            ST_W_MUL: begin
                w_op_state = 1'b1;
                w_a = 64'($signed({1'b0, r_radius}));
                w_b = 64'(r_dr) - 64'(r_dl);
                n_state = ST_W_DIV;
            end
            ST_W_DIV: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_bypass = (r_sep == '0);
                w_a = r_p;
                w_b = 64'($signed({1'b0, r_sep}));
                n_state = ST_V_MUL;
            end
            ST_V_MUL: begin
                w_op_state = 1'b1;
                w_a = 64'($signed({1'b0, r_radius}));
                w_b = 64'(r_dr) + 64'(r_dl);
                n_state = ST_WRAP;
            end
            ST_WRAP: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_a = 64'(w_wsrc) <<< SH30;
                w_b = TWO_PI30;
                unique case (r_ctx)
                    WC_W, WC_HEAD:           n_state = ST_SC_INIT;
                    WC_RNEW, WC_LDR:         n_state = ST_OUT;
                    WC_HNEW, WC_LNEW,
                    WC_LDH, WC_LDL:          n_state = ST_WRAP;
                endcase
            end
            ST_SC_INIT: n_state = ST_SC_SQ;
            ST_SC_SQ: begin
                w_op_state = 1'b1;
                w_a = 64'(r_m);
                w_b = 64'(r_m);
                n_state = ST_SC_TM;
            end
            ST_SC_TM: begin
                w_op_state = 1'b1;
                w_a = 64'(r_t);
                w_b = 64'(r_b2);
                n_state = ST_SC_TD;
            end
            ST_SC_TD: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_a = r_p;
                w_b = 64'(term_div(r_cos, r_n));
                n_state = (r_cos && r_n == 4'd8) ? ST_SC_FIN : ST_SC_TM;
            end
            ST_SC_FIN: n_state = (r_ctx == WC_W) ? ST_DX_MUL : ST_EX_MUL1;
            ST_DX_MUL: begin
                w_op_state = 1'b1;
                w_a = 64'(r_vx);
                w_b = 64'(r_sw);
                n_state = ST_DX_DIV;
            end
            ST_DX_DIV: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_a = r_p;
                w_b = w_den;
                n_state = ST_DY_MUL;
            end
            ST_DY_MUL: begin
                w_op_state = 1'b1;
                w_a = 64'(r_vx);
                w_b = ONE30 - 64'(r_cw);
                n_state = ST_DY_DIV;
            end
            ST_DY_DIV: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_a = r_p;
                w_b = w_den;
                n_state = ST_WRAP;
            end
            ST_EX_MUL1: begin
                w_op_state = 1'b1;
                w_a = 64'(r_ch);
                w_b = 64'(r_dx);
                n_state = ST_EX_MUL2;
            end
            ST_EX_MUL2: begin
                w_op_state = 1'b1;
                w_a = 64'(r_sh);
                w_b = 64'(r_dy);
                n_state = ST_EY_MUL1;
            end
            ST_EY_MUL1: begin
                w_op_state = 1'b1;
                w_a = 64'(r_sh);
                w_b = 64'(r_dx);
                n_state = ST_EY_MUL2;
            end
            ST_EY_MUL2: begin
                w_op_state = 1'b1;
                w_a = 64'(r_ch);
                w_b = 64'(r_dy);
                n_state = ST_WRAP;
            end
            ST_R_MUL: begin
                w_op_state = 1'b1;
                w_a = 64'($signed({1'b0, r_sep}));
                w_b = 64'(r_tw);
                n_state = ST_RL_DIV;
            end
            ST_RL_DIV: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_bypass = (r_radius == '0);
                w_a = w_base - r_p;
                w_b = 64'($signed({1'b0, r_radius})) <<< 1;
                n_state = ST_RR_DIV;
            end
            ST_RR_DIV: begin
                w_op_state = 1'b1;
                w_req.op = AOP_DIV;
                w_bypass = (r_radius == '0);
                w_a = w_base + r_p;
                w_b = 64'($signed({1'b0, r_radius})) <<< 1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
        w_req.start = w_op_state && !r_issued && !w_bypass;
        w_adv = !w_op_state || w_bypass || w_done;
        if (!w_adv) begin
            n_state = r_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (w_done) begin
                r_issued <= 1'b0;
            end
        end
    end

    dd_odo_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res),
        .o_rem   (w_rem)
    );

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_px   <= '0;
            r_py   <= '0;
            r_la   <= '0;
            r_ra   <= '0;
        end else if (w_op_state ? (w_bypass || w_done) : 1'b1) begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_dl  <= s_axis_tdata[31:0];
                        r_dr  <= s_axis_tdata[63:32];
                        r_tw  <= s_axis_tdata[95:64];
                        r_tx  <= s_axis_tdata[127:96];
                        r_w   <= '0;
                        r_vx  <= '0;
                        r_rl  <= '0;
                        r_rr  <= '0;
                        r_inv <= (w_func == FN_RATE) && (s_axis_tdata[159:128] != '0);
                        if (w_func == FN_LOAD) begin
                            r_px  <= r_sx;
                            r_py  <= r_sy;
                            r_ctx <= WC_LDH;
                        end
                    end
                end
                ST_W_MUL:  r_p <= w_res;
                ST_W_DIV:  r_w <= w_bypass ? sat_sign(r_p) : sat32(w_res);
                ST_V_MUL: begin
                    r_vx <= w_vx_new;
                    if (r_w != '0) begin
                        r_ctx <= WC_W;
                    end else begin
                        r_ctx <= WC_HEAD;
                        r_dx  <= w_vx_new;
                        r_dy  <= '0;
                    end
                end
                ST_WRAP: begin
                    r_ang <= w_ang;
                    unique case (r_ctx)
                        WC_W, WC_HEAD: ;
                        WC_HNEW: begin
                            r_head <= to_qf(w_ang);
                            r_ctx  <= WC_LNEW;
                        end
                        WC_LNEW: begin
                            r_la  <= to_qf(w_ang);
                            r_ctx <= WC_RNEW;
                        end
                        WC_RNEW: r_ra <= to_qf(w_ang);
                        WC_LDH: begin
                            r_head <= to_qf(w_ang);
                            r_ctx  <= WC_LDL;
                        end
                        WC_LDL: begin
                            r_la  <= to_qf(w_ang);
                            r_ctx <= WC_LDR;
                        end
                        WC_LDR: r_ra <= to_qf(w_ang);
                    endcase
                end
                ST_SC_INIT: begin
                    r_m    <= w_m;
                    r_quad <= w_quad;
                    r_bneg <= r_ang[32] ^ w_bred[34];
                end
                ST_SC_SQ: begin
                    r_b2  <= w_res[60:30];
                    r_t   <= 31'(r_m);
                    r_acc <= 32'(r_m);
                    r_n   <= 4'd1;
                    r_cos <= 1'b0;
                end
                ST_SC_TM: r_p <= w_res >>> 30;
                ST_SC_TD: begin
                    // last sine term switches the series over to cosine
                    if (!r_cos && r_n == 4'd7) begin
                        r_sb  <= r_bneg ? -w_accnew : w_accnew;
                        r_cos <= 1'b1;
                        r_n   <= 4'd1;
                        r_t   <= 31'(ONE30);
                        r_acc <= 32'(ONE30);
                    end else begin
                        r_acc <= w_accnew;
                        r_t   <= w_tnew;
                        r_n   <= r_n + 4'd1;
                    end
                end
                ST_SC_FIN: begin
                    logic signed [31:0] s_v;
                    logic signed [31:0] c_v;
                    unique case (r_quad)
                        2'd0: begin s_v = r_sb;   c_v = r_acc;  end
                        2'd1: begin s_v = r_acc;  c_v = -r_sb;  end
                        2'd2: begin s_v = -r_sb;  c_v = -r_acc; end
                        2'd3: begin s_v = -r_acc; c_v = r_sb;   end
                    endcase
                    if (r_ctx == WC_W) begin
                        r_sw <= s_v;
                        r_cw <= c_v;
                    end else begin
                        r_sh <= s_v;
                        r_ch <= c_v;
                    end
                end
                ST_DX_MUL: r_p <= w_res;
                ST_DX_DIV: r_dx <= sat32(w_res);
                ST_DY_MUL: r_p <= w_res;
                ST_DY_DIV: begin
                    r_dy  <= sat32(w_res);
                    r_ctx <= WC_HEAD;
                end
                ST_EX_MUL1: r_p <= w_res;
                ST_EX_MUL2: r_px <= sat32(64'(r_px) + shr_trunc(r_p - w_res, 30));
                ST_EY_MUL1: r_p <= w_res;
                ST_EY_MUL2: begin
                    r_py  <= sat32(64'(r_py) + shr_trunc(r_p + w_res, 30));
                    r_ctx <= WC_HNEW;
                end
                ST_R_MUL:  r_p <= w_res;
                ST_RL_DIV: r_rl <= w_bypass ? sat_sign(w_base - r_p) : sat32(w_res);
                ST_RR_DIV: r_rr <= w_bypass ? sat_sign(w_base + r_p) : sat32(w_res);
                ST_OUT: ;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {7'd0, r_ra[18:0], r_la[18:0], r_py, r_px, r_head[18:0],
                            r_rr, r_rl, r_vx, r_w};
    assign m_axis_tuser  = r_inv;

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid && !r_issued)
        else $error("request taken while another is in flight");
    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (64'(r_head) <= HEAD_MAX) && (64'(r_head) >= -HEAD_MAX))
        else $error("heading outside (-pi, pi]");
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_inv |-> r_rl == '0 && r_rr == '0)
        else $error("wheel rates nonzero on invalid twist");
    a_done_in_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_issued && w_op_state)
        else $error("arith result outside an arithmetic step");
`endif
endmodule
